// File: hdl/rmh_pkg.sv
package rmh_pkg;

  localparam int unsigned CAPACITY = 65536;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned KID_W    = ADDR_W + 2;
  localparam int unsigned DATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic OP_START = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_UP_CHK = 11'b000_0000_0010,
    ST_UP_CMP = 11'b000_0000_0100,
    ST_BAL    = 11'b000_0000_1000,
    ST_NEXT   = 11'b000_0001_0000,
    ST_DN_CHK = 11'b000_0010_0000,
    ST_DN_RD  = 11'b000_0100_0000,
    ST_DN_SEL = 11'b000_1000_0000,
    ST_DN_CMP = 11'b001_0000_0000,
    ST_DN_END = 11'b010_0000_0000,
    ST_OUT    = 11'b100_0000_0000
  } rmh_state_e;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr;
  } rmh_mem_req_t;

endpackage

// File: hdl/rmh_heap.sv
module rmh_heap
  import rmh_pkg::*;
(
  input  logic                     clk_i,
  input  rmh_mem_req_t             req_i,
  output logic signed [DATA_W-1:0] rdata_o,
  output logic signed [DATA_W-1:0] root_o
);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] root_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  // The root is mirrored in a register so that balancing needs no read.
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == '0)) begin
      root_q <= req_i.wdata;
    end
  end

  assign rdata_o = rdata_q;
  assign root_o  = root_q;

endmodule

// File: hdl/rmh_cmp.sv
module rmh_cmp
  import rmh_pkg::*;
(
  input  logic                     is_max_i,
  input  logic signed [DATA_W-1:0] a_i,
  input  logic signed [DATA_W-1:0] b_i,
  output logic                     above_o
);

  assign above_o = is_max_i ? (a_i > b_i) : (a_i < b_i);

endmodule

// File: hdl/running_median_two_heaps.sv
// Running median over a growing multiset of signed 32-bit values.
// Input words arrive on the s_ channel: tuser carries the opcode (start or add),
// tdata carries the first value in bits 31:0 and the second in bits 63:32.
// A start word empties both heaps and seeds the lower heap; an add word pushes
// the first value into the upper min-heap and the second into the lower max-heap.
// One result word per input word leaves on the m_ channel: tdata is the median,
// tuser is set when an add was rejected because a heap was full.
// A start or rejected word goes from acceptance straight to the output state.
// An add takes longer, most of all when both pushes climb to the root and each
// balancing pass walks to a leaf: a single compare unit serves every sift step
// and each heap memory gives one registered read per cycle.
// The block works on one word at a time; s_tready is high only while it is idle.
// A finished result waits in the output register while the receiver stalls,
// and a new word may be accepted meanwhile, but that word's result waits for it.
// Reset empties both heaps at once; the heap memories need no clearing pass.
module running_median_two_heaps
  import rmh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [63:0]              s_tdata_i,  // first_value, second_value
  input  logic                     s_tuser_i,  // opcode
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic signed [DATA_W-1:0] m_tdata_o,  // median
  output logic                     m_tuser_o   // overflow
);

  rmh_state_e               state_q, state_d;
  logic                     hsel_q, hsel_d;
  logic                     phase_q, phase_d;
  logic                     dn2_q, dn2_d;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic [ADDR_W-1:0]        bidx_q, bidx_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] tmp_q, tmp_d;
  logic signed [DATA_W-1:0] b_q, b_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic signed [DATA_W-1:0] med_q, med_d;
  logic [CNT_W-1:0]         lcnt_q, lcnt_d;
  logic [CNT_W-1:0]         ucnt_q, ucnt_d;
  logic                     ovf_q, ovf_d;
  logic                     ovf_out_q, ovf_out_d;
  logic                     ovalid_q, ovalid_d;

  rmh_mem_req_t             req, req_l, req_u;
  logic                     tgt;
  logic signed [DATA_W-1:0] rd_l, rd_u, root_l, root_u, rd_sel;
  logic                     cmp_max, above;
  logic signed [DATA_W-1:0] cmp_a, cmp_b;
  logic [CNT_W-1:0]         cnt_sel;
  logic [KID_W-1:0]         kid, kid1;
  logic [ADDR_W-1:0]        par;
  logic                     accept;
  logic signed [DATA_W-1:0] in_first, in_second;

  assign in_first  = s_tdata_i[31:0];
  assign in_second = s_tdata_i[63:32];
  assign accept    = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == ST_IDLE);

  assign cnt_sel = hsel_q ? ucnt_q : lcnt_q;
  assign kid     = {1'b0, pos_q, 1'b1};
  assign kid1    = kid + KID_W'(1);
  assign par     = (pos_q - ADDR_W'(1)) >> 1;
  assign rd_sel  = hsel_q ? rd_u : rd_l;

  rmh_heap u_lower (.clk_i(clk_i), .req_i(req_l), .rdata_o(rd_l), .root_o(root_l));
  rmh_heap u_upper (.clk_i(clk_i), .req_i(req_u), .rdata_o(rd_u), .root_o(root_u));

  rmh_cmp u_cmp (.is_max_i(cmp_max), .a_i(cmp_a), .b_i(cmp_b), .above_o(above));

  assign tgt = (state_q == ST_IDLE) ? HEAP_LOWER : hsel_q;

  always_comb begin
    req_l    = req;
    req_u    = req;
    req_l.we = req.we && (tgt == HEAP_LOWER);
    req_u.we = req.we && (tgt == HEAP_UPPER);
  end

  always_comb begin
    cmp_max = (hsel_q == HEAP_LOWER);
    cmp_a   = val_q;
    cmp_b   = rd_sel;
    unique case (state_q)
      ST_BAL: begin
        cmp_max = 1'b1;
        cmp_a   = root_l;
        cmp_b   = root_u;
      end
      ST_DN_SEL: begin
        cmp_a = rd_sel;
        cmp_b = best_q;
      end
      ST_DN_CMP: begin
        cmp_a = best_q;
        cmp_b = val_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    hsel_d    = hsel_q;
    phase_d   = phase_q;
    dn2_d     = dn2_q;
    pos_d     = pos_q;
    bidx_d    = bidx_q;
    val_d     = val_q;
    tmp_d     = tmp_q;
    b_d       = b_q;
    best_d    = best_q;
    med_d     = med_q;
    lcnt_d    = lcnt_q;
    ucnt_d    = ucnt_q;
    ovf_d     = ovf_q;
    ovf_out_d = ovf_out_q;
    ovalid_d  = ovalid_q && !m_tready_i;
    req       = '{we: 1'b0, waddr: pos_q, wdata: val_q, raddr: pos_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ovf_d = 1'b0;
          if (s_tuser_i == OP_START) begin
            req.we    = 1'b1;
            req.waddr = '0;
            req.wdata = in_first;
            lcnt_d    = CNT_W'(1);
            ucnt_d    = '0;
            state_d   = ST_OUT;
          end else if ((lcnt_q == CAP_CNT) || (ucnt_q == CAP_CNT)) begin
            ovf_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            hsel_d  = HEAP_UPPER;
            phase_d = 1'b0;
            pos_d   = ucnt_q[ADDR_W-1:0];
            val_d   = in_first;
            b_d     = in_second;
            ucnt_d  = ucnt_q + CNT_W'(1);
            state_d = ST_UP_CHK;
          end
        end
      end
      ST_UP_CHK: begin
        if (pos_q == '0) begin
          req.we  = 1'b1;
          state_d = ST_BAL;
        end else begin
          req.raddr = par;
          state_d   = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        req.we = 1'b1;
        if (above) begin
          req.wdata = rd_sel;
          pos_d     = par;
          state_d   = ST_UP_CHK;
        end else begin
          state_d = ST_BAL;
        end
      end
      ST_BAL: begin
        if ((lcnt_q != '0) && (ucnt_q != '0) && above) begin
          hsel_d  = HEAP_LOWER;
          val_d   = root_u;
          tmp_d   = root_l;
          pos_d   = '0;
          dn2_d   = 1'b0;
          state_d = ST_DN_CHK;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          hsel_d  = HEAP_LOWER;
          pos_d   = lcnt_q[ADDR_W-1:0];
          val_d   = b_q;
          lcnt_d  = lcnt_q + CNT_W'(1);
          state_d = ST_UP_CHK;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DN_CHK: begin
        if (kid >= KID_W'(cnt_sel)) begin
          req.we  = 1'b1;
          state_d = ST_DN_END;
        end else begin
          req.raddr = kid[ADDR_W-1:0];
          state_d   = ST_DN_RD;
        end
      end
      ST_DN_RD: begin
        best_d = rd_sel;
        bidx_d = kid[ADDR_W-1:0];
        if (kid1 < KID_W'(cnt_sel)) begin
          req.raddr = kid1[ADDR_W-1:0];
          state_d   = ST_DN_SEL;
        end else begin
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_SEL: begin
        if (above) begin
          best_d = rd_sel;
          bidx_d = kid1[ADDR_W-1:0];
        end
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        req.we = 1'b1;
        if (above) begin
          req.wdata = best_q;
          pos_d     = bidx_q;
          state_d   = ST_DN_CHK;
        end else begin
          state_d = ST_DN_END;
        end
      end
      ST_DN_END: begin
        if (!dn2_q) begin
          dn2_d   = 1'b1;
          hsel_d  = HEAP_UPPER;
          val_d   = tmp_q;
          pos_d   = '0;
          state_d = ST_DN_CHK;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || m_tready_i) begin
          ovalid_d  = 1'b1;
          med_d     = (lcnt_q != '0) ? root_l : '0;
          ovf_out_d = ovf_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      lcnt_q   <= '0;
      ucnt_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lcnt_q   <= lcnt_d;
      ucnt_q   <= ucnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hsel_q    <= hsel_d;
    phase_q   <= phase_d;
    dn2_q     <= dn2_d;
    pos_q     <= pos_d;
    bidx_q    <= bidx_d;
    val_q     <= val_d;
    tmp_q     <= tmp_d;
    b_q       <= b_d;
    best_q    <= best_d;
    med_q     <= med_d;
    ovf_q     <= ovf_d;
    ovf_out_q <= ovf_out_d;
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = med_q;
  assign m_tuser_o  = ovf_out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lcnt_q <= CAP_CNT) && (ucnt_q <= CAP_CNT))
    else $error("heap count beyond capacity");

  a_start_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (s_tuser_i == OP_START)) |=> (lcnt_q == CNT_W'(1)) && (ucnt_q == '0))
    else $error("start word did not reset the counts");

  a_sift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UP_CHK) || (state_q == ST_DN_CHK)) |-> (cnt_sel != '0))
    else $error("sift on an empty heap");

endmodule
